>>> rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants for the sorted insert list unit
// Store depth, field widths and the walk state machine encoding.
// ----------------------------------------------------------------------------
package sil_pkg;

    // store depth, 1 to 32
    localparam int CAPACITY = 32;

    // field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;

    // index into the store, and a count that can hold CAPACITY itself
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } sil_state_t;

endpackage

>>> rtl/sorted_insert_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_list_unit: ascending list with insert-and-list per word
//
// Input channel (item_valid/item_ready, new_value) takes one signed 32-bit
// word. The value goes into the stored ascending list just after any equal
// entries. The output channel (result_valid/result_ready) then carries the
// whole list, smallest first, one word per entry, with entry_position,
// last_of_list on the final word, and dropped on every word when the store
// was already full and the value was discarded.
// Each input word starts one walk that produces the whole listing, and the
// unit returns to idle before it takes the next word. The walk reads one entry
// per cycle from the store and writes it back one place behind the read,
// shifted up past the insert point, in the same pass that produces the listing.
// A stalled receiver freezes the walk; the held read data waits in place.
// item_ready is high only between walks. Reset empties the list; the store
// itself needs no clearing since entries at or above the count are never
// used.
// ----------------------------------------------------------------------------
module sorted_insert_list_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [sil_pkg::VALUE_W-1:0] new_value,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [sil_pkg::VALUE_W-1:0] entry_value,
    output logic        [sil_pkg::POS_W-1:0]   entry_position,
    output logic                               last_of_list,
    output logic                               dropped
);
    import sil_pkg::*;

    // entry store with a registered read port
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    // control
    sil_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               pend_reg, pend_next;
    logic               ins_reg, ins_next;
    logic               drop_reg, drop_next;

    // payload of the walk
    logic signed [VALUE_W-1:0] new_reg;
    logic [VALUE_W-1:0]        carry_reg;

    // output word register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [POS_W-1:0]          out_pos_reg;
    logic                      out_last_reg;
    logic                      out_drop_reg;

    logic               accept;
    logic               out_free;
    logic               fire;
    logic               issue;
    logic               at_end;
    logic               take_new;
    logic               is_last;
    logic               full;
    logic [VALUE_W-1:0] word_val;
    logic               do_write;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign full       = (count_reg == CNT_W'(CAPACITY));

    // walk step: emit when read data is held and the output can take it
    assign out_free = !out_valid_reg || result_ready;
    assign fire     = (state_reg == ST_WALK) && pend_reg && out_free;
    assign issue    = (state_reg == ST_WALK) && (rd_ptr_reg < total_reg)
                      && (!pend_reg || fire);

    // pick the word for this position: new value, shifted carry or unchanged
    assign at_end   = (pos_reg == count_reg);
    assign take_new = !drop_reg && !ins_reg
                      && (at_end || (new_reg < $signed(rdata_reg)));
    assign word_val = take_new ? new_reg : (ins_reg ? carry_reg : rdata_reg);
    assign do_write = fire && !drop_reg && (take_new || ins_reg);
    assign is_last  = (CNT_W'(pos_reg + 1'b1) == total_reg);

    // next-state logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        rd_ptr_next = rd_ptr_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        ins_next    = ins_reg;
        drop_next   = drop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_WALK;
                    rd_ptr_next = '0;
                    pos_next    = '0;
                    pend_next   = 1'b0;
                    ins_next    = 1'b0;
                    drop_next   = full;
                    total_next  = full ? count_reg : CNT_W'(count_reg + 1'b1);
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    rd_ptr_next = CNT_W'(rd_ptr_reg + 1'b1);
                end
                if (issue)
                begin
                    pend_next = 1'b1;
                end
                else if (fire)
                begin
                    pend_next = 1'b0;
                end
                if (fire)
                begin
                    pos_next = CNT_W'(pos_reg + 1'b1);
                    if (take_new)
                    begin
                        ins_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                        count_next = total_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rd_ptr_reg    <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            rd_ptr_reg <= rd_ptr_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            ins_reg    <= ins_next;
            drop_reg   <= drop_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_reg <= new_value;
        end
        if (fire)
        begin
            carry_reg     <= rdata_reg;
            out_value_reg <= word_val;
            out_pos_reg   <= POS_W'(pos_reg);
            out_last_reg  <= is_last;
            out_drop_reg  <= drop_reg;
        end
    end

    // store: write behind, read ahead; addresses never meet in one cycle
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[pos_reg[IDX_W-1:0]] <= word_val;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    assign result_valid   = out_valid_reg;
    assign entry_value    = out_value_reg;
    assign entry_position = out_pos_reg;
    assign last_of_list   = out_last_reg;
    assign dropped        = out_drop_reg;

endmodule

>>> rtl/sil_checker.sv
// ----------------------------------------------------------------------------
// sil_checker: port-level checks for the sorted insert list unit
// Watches listing order and the input interlock over time.
// ----------------------------------------------------------------------------
module sil_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [sil_pkg::VALUE_W-1:0] entry_value,
    input logic        [sil_pkg::POS_W-1:0]   entry_position,
    input logic                               last_of_list,
    input logic                               dropped
);
    import sil_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(entry_value) && $stable(entry_position))
        else $error("stalled result word changed");

    // one input word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input accepted while a walk runs");

    // within a listing positions count up by one and the drop flag holds
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_of_list |=>
            !result_valid || ((entry_position == $past(entry_position) + 5'd1)
                              && (dropped == $past(dropped))))
        else $error("listing out of order");

    // a new listing starts at position zero
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && last_of_list |=>
            !result_valid || (entry_position == '0))
        else $error("listing does not start at zero");

endmodule

bind sorted_insert_list_unit sil_checker u_sil_checker (.*);
